@@ sv/teq_pkg.sv @@
// ----------------------------------------------------------------------------
// teq_pkg - shared types and codes for the timed event queue
// Command codes, result codes, the stored entry and the per-cell control word.
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int unsigned MODE_W   = 2;
	localparam int unsigned ID_W     = 8;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_SCHEDULE = 2'd0,
		MODE_CANCEL   = 2'd1,
		MODE_SAMPLE   = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_IDLE  = 2'd0,
		STATUS_FIRED = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// one queue slot
	typedef struct packed {
		logic              valid;
		logic              never;
		logic [TIME_W-1:0] due;
		logic [ID_W-1:0]   id;
	} entry_t;

	// broadcast to every cell for the current item
	typedef struct packed {
		logic              insert;
		logic              cancel;
		logic              fire;
		logic              never;
		logic [TIME_W-1:0] due;
		logic [ID_W-1:0]   id;
	} ctrl_t;

endpackage

@@ sv/teq_cmd_if.sv @@
// ----------------------------------------------------------------------------
// teq_cmd_if - command channel of the timed event queue
// valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface teq_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [teq_pkg::MODE_W-1:0]   mode;
	logic [teq_pkg::ID_W-1:0]     event_id;
	logic [teq_pkg::TIME_W-1:0]   event_time;
	logic                         never_due;
	logic [teq_pkg::TIME_W-1:0]   clock_time;

	modport source (output valid, mode, event_id, event_time, never_due, clock_time,
		input ready);
	modport sink (input valid, mode, event_id, event_time, never_due, clock_time,
		output ready);
endinterface

@@ sv/teq_res_if.sv @@
// ----------------------------------------------------------------------------
// teq_res_if - result channel of the timed event queue
// valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface teq_res_if;
	logic                         valid;
	logic                         ready;
	logic [teq_pkg::STATUS_W-1:0] status;
	logic [teq_pkg::ID_W-1:0]     fired_id;

	modport source (output valid, status, fired_id, input ready);
	modport sink (input valid, status, fired_id, output ready);
endinterface

@@ sv/teq_cell.sv @@
// ----------------------------------------------------------------------------
// teq_cell - one slot of the sorted shift chain
// Holds an entry; per item it holds, takes the new key, takes its left
// neighbour (insert shift) or takes its right neighbour (removal shift).
// ----------------------------------------------------------------------------
module teq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  teq_pkg::ctrl_t  ctrl,
	input  teq_pkg::entry_t prev_entry,
	input  logic            prev_gt,
	input  teq_pkg::entry_t next_entry,
	input  logic            match_in,
	output teq_pkg::entry_t entry,
	output logic            gt,
	output logic            match_out
);

	logic                       valid_q;
	logic                       never_q;
	logic [teq_pkg::TIME_W-1:0] due_q;
	logic [teq_pkg::ID_W-1:0]   id_q;
	teq_pkg::entry_t            cur_entry;
	teq_pkg::entry_t            entry_d;
	logic                       shift_left;

	assign cur_entry = '{valid: valid_q, never: never_q, due: due_q, id: id_q};

	// slot sorts strictly after the new key (empty slots count as after)
	always_comb begin
		if (!cur_entry.valid) begin
			gt = 1'b1;
		end else if (cur_entry.never) begin
			gt = !ctrl.never;
		end else begin
			gt = !ctrl.never && (cur_entry.due > ctrl.due);
		end
	end

	// first matching slot at or to the left of this one
	assign match_out  = match_in || (cur_entry.valid && (cur_entry.id == ctrl.id));
	assign shift_left = ctrl.fire || (ctrl.cancel && match_out);

	always_comb begin
		entry_d = cur_entry;
		priority if (ctrl.insert && gt && !prev_gt) begin
			entry_d.valid = 1'b1;
			entry_d.never = ctrl.never;
			entry_d.due   = ctrl.due;
			entry_d.id    = ctrl.id;
		end else if (ctrl.insert && gt) begin
			entry_d = prev_entry;
		end else if (shift_left) begin
			entry_d = next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		never_q <= entry_d.never;
		due_q   <= entry_d.due;
		id_q    <= entry_d.id;
	end

	assign entry = cur_entry;

endmodule

@@ sv/timed_event_queue.sv @@
// ----------------------------------------------------------------------------
// timed_event_queue - time-sorted event queue built as a shift-insert chain
// Keeps up to QUEUE_DEPTH events in ascending due order, never-due last,
// ties in arrival order; schedules, cancels and fires the head on a sample.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                        | handshake
//   --------+-----+------------------------------------------------+-----------
//   cmd     | in  | mode, event_id, event_time, never_due,         | valid/ready
//           |     | clock_time                                     |
//   res     | out | status, fired_id                               | valid/ready
//
// One item per cycle: every cell decides its next content from its own
// compare and its neighbours, so a schedule, cancel or sample completes in
// the cycle it is accepted and its result sits in the output register next.
// Reset clears every cell's valid bit (empty queue) and the result valid flag.
// A stalled result holds cmd.ready low until res is taken; there is no other
// wait state.
//
module timed_event_queue #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	teq_cmd_if.sink  cmd,
	teq_res_if.source res
);

	teq_pkg::entry_t                 cell_entry [QUEUE_DEPTH];
	logic            [QUEUE_DEPTH-1:0] cell_gt;
	logic            [QUEUE_DEPTH-1:0] cell_match;
	teq_pkg::ctrl_t                  ctrl;
	teq_pkg::mode_t                  mode;
	teq_pkg::entry_t                 empty_entry;

	logic                            accept;
	logic                            full;
	logic                            head_due;
	teq_pkg::status_t                status_d;
	logic [teq_pkg::ID_W-1:0]        fired_d;

	logic                            res_valid_q;
	teq_pkg::status_t                status_q;
	logic [teq_pkg::ID_W-1:0]        fired_q;

	// output register frees the command side as soon as the result is taken
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign mode      = teq_pkg::mode_t'(cmd.mode);

	// queue is full once the last slot is occupied (valid bits form a prefix)
	assign full     = cell_entry[QUEUE_DEPTH-1].valid;
	// head fires if it is timed and its due time has been reached
	assign head_due = cell_entry[0].valid && !cell_entry[0].never
		&& (cell_entry[0].due <= cmd.clock_time);

	// broadcast word; only one of insert, cancel, fire per item
	always_comb begin
		ctrl        = '0;
		ctrl.never  = cmd.never_due;
		ctrl.due    = cmd.event_time;
		ctrl.id     = cmd.event_id;
		status_d    = teq_pkg::STATUS_IDLE;
		fired_d     = '0;
		unique case (mode)
			teq_pkg::MODE_SCHEDULE: begin
				if (full) begin
					status_d = teq_pkg::STATUS_FULL;
				end else begin
					ctrl.insert = accept;
				end
			end
			teq_pkg::MODE_CANCEL: begin
				ctrl.cancel = accept;
			end
			teq_pkg::MODE_SAMPLE: begin
				if (head_due) begin
					ctrl.fire = accept;
					status_d  = teq_pkg::STATUS_FIRED;
					fired_d   = cell_entry[0].id;
				end
			end
			default: begin
			end
		endcase
	end

	// chain ends: nothing to the left sorts after, nothing beyond the right end
	assign empty_entry = '0;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		teq_pkg::entry_t prev_entry;
		teq_pkg::entry_t next_entry;
		logic            prev_gt;
		logic            match_in;

		if (k == 0) begin : g_first
			assign prev_entry = empty_entry;
			assign prev_gt    = 1'b0;
			assign match_in   = 1'b0;
		end else begin : g_mid
			assign prev_entry = cell_entry[k-1];
			assign prev_gt    = cell_gt[k-1];
			assign match_in   = cell_match[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_last
			assign next_entry = empty_entry;
		end else begin : g_inner
			assign next_entry = cell_entry[k+1];
		end

		teq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry (prev_entry),
			.prev_gt    (prev_gt),
			.next_entry (next_entry),
			.match_in   (match_in),
			.entry      (cell_entry[k]),
			.gt         (cell_gt[k]),
			.match_out  (cell_match[k])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			fired_q  <= fired_d;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.status   = status_q;
	assign res.fired_id = fired_q;

endmodule
